[design/bhpn_pkg.sv]
package bhpn_pkg;

    localparam int COUNT_BITS = 22;
    localparam int NUM_BINS   = 256;
    localparam int ADDR_BITS  = 8;
    localparam int QUOT_BITS  = 8;
    localparam int HEIGHT_BITS = 9;
    localparam int STEP_BITS  = 4;

    localparam logic [HEIGHT_BITS-1:0] FULL_SCALE = HEIGHT_BITS'(256);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};

    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 56;

    localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
    localparam logic [1:0] CMD_QUERY      = 2'd1;
    localparam logic [1:0] CMD_CLEAR      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_QRY,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [COUNT_BITS-1:0] wr_data;
        logic                  clr;
    } ram_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic                 sat;
        logic [QUOT_BITS-1:0] quot;
    } div_stat_t;

endpackage

[design/bhpn_bin_ram.sv]
module bhpn_bin_ram import bhpn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ram_req_t              req,
    output logic [COUNT_BITS-1:0] rd_data
);

    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]   valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    // valid bits make a cleared bin read as zero without a sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clr) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg  <= mem[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[design/bhpn_divider.sv]
module bhpn_divider import bhpn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [COUNT_BITS-1:0] peak,
    output div_stat_t             stat
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  sat_reg, sat_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [QUOT_BITS-1:0]  quot_reg, quot_next;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS+1:0] diff;
    logic                  ge;

    // one shared compare/subtract; step zero checks count >= peak, later steps shift in
    always_comb begin
        trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff  = {1'b0, trial} - {2'b00, peak};
        ge    = !diff[COUNT_BITS+1];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            sat_next  = 1'b0;
            step_next = '0;
            rem_next  = count;
            quot_next = '0;
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                if (ge) begin
                    sat_next  = 1'b1;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else begin
                rem_next  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], ge};
                if (step_reg == STEP_BITS'(QUOT_BITS)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sat_reg  <= sat_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign stat.quot = quot_reg;

endmodule

[design/byte_histogram_peak_normalize.sv]
// 256-bin histogram of 8-bit pixels with a running peak bin count.
// input stream s_*: one transaction carries one command (accumulate, query or
// clear); every command gives exactly one result transaction on m_*.
// accumulate adds one to the bin of pixel_value, saturating at the top of the
// count range; query returns the bin count, the peak and a plot height of
// 256 - floor(count*256/peak); clear empties every bin and the peak.
// a query reads the bin count from the bin memory and, unless the histogram is
// empty, then runs the shared compare/subtract unit: first a range check, then
// one quotient bit per cycle over 8 bits. s_tready is high only while no command
// is in progress, so the block takes a new command only once the last one has
// handed its result to the output register. a finished result sits there; the
// next command is accepted while it waits, and only the completion of that next
// command waits on m_tready. reset empties the histogram at once (per-bin valid
// bits, no sweep), zeroes the peak and drops any pending result.
module byte_histogram_peak_normalize import bhpn_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // command[1:0], pixel_value[9:2], bin_index[17:10], zero fill
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // bin_count[21:0], peak_count[43:22], plot_height[52:44], empty_flag[53], zero fill
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    state_t                  state_reg, state_next;
    logic [1:0]              cmd;
    logic [ADDR_BITS-1:0]    pixel_value;
    logic [ADDR_BITS-1:0]    bin_index;
    logic                    s_accept;

    logic [ADDR_BITS-1:0]    addr_reg, addr_next;
    logic [COUNT_BITS-1:0]   peak_reg, peak_next;
    logic [COUNT_BITS-1:0]   res_count_reg, res_count_next;
    logic [HEIGHT_BITS-1:0]  res_height_reg, res_height_next;
    logic                    res_empty_reg, res_empty_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    ram_req_t                ram_req;
    logic [COUNT_BITS-1:0]   rd_data;
    logic [COUNT_BITS-1:0]   count_inc;
    logic                    div_start;
    div_stat_t               div_stat;

    assign cmd         = s_tdata[1:0];
    assign pixel_value = s_tdata[9:2];
    assign bin_index   = s_tdata[17:10];
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;

    assign count_inc = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

    bhpn_bin_ram u_bin_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // the divider loads the bin count straight from the memory read port
    bhpn_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .count   (rd_data),
        .peak    (peak_reg),
        .stat    (div_stat)
    );

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        peak_next       = peak_reg;
        res_count_next  = res_count_reg;
        res_height_next = res_height_reg;
        res_empty_next  = res_empty_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        div_start       = 1'b0;

        ram_req         = '0;
        ram_req.rd_addr = (cmd == CMD_QUERY) ? bin_index : pixel_value;
        ram_req.wr_addr = addr_reg;
        ram_req.wr_data = count_inc;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ram_req.rd_en   = 1'b1;
                    addr_next       = ram_req.rd_addr;
                    res_count_next  = '0;
                    res_height_next = '0;
                    res_empty_next  = 1'b0;
                    case (cmd)
                        CMD_ACCUMULATE: state_next = ST_ACC;
                        CMD_QUERY:      state_next = ST_QRY;
                        CMD_CLEAR: begin
                            ram_req.clr = 1'b1;
                            peak_next   = '0;
                            state_next  = ST_DONE;
                        end
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_ACC: begin
                ram_req.wr_en = 1'b1;
                if (count_inc > peak_reg) begin
                    peak_next = count_inc;
                end
                state_next = ST_DONE;
            end
            ST_QRY: begin
                res_count_next = rd_data;
                if (peak_reg == '0) begin
                    res_height_next = FULL_SCALE;
                    res_empty_next  = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    res_height_next = div_stat.sat ? '0
                                    : FULL_SCALE - {1'b0, div_stat.quot};
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                // output register free or draining this cycle
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_empty_reg, res_height_reg,
                                     peak_reg, res_count_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            peak_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            peak_reg     <= peak_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        addr_reg       <= addr_next;
        res_count_reg  <= res_count_next;
        res_height_reg <= res_height_next;
        res_empty_reg  <= res_empty_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/bhpn_checker.sv]
module bhpn_checker import bhpn_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // one command at a time: ready falls after every input transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a command is in progress");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // empty histogram reads as full height with a zero peak
    a_empty_height: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[53]) |-> (m_tdata[52:44] == 9'd256 && m_tdata[43:22] == '0))
        else $error("empty flag without full height and zero peak");

    a_count_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:0] <= m_tdata[43:22]))
        else $error("bin count above peak");

endmodule

bind byte_histogram_peak_normalize bhpn_checker u_bhpn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/byte_histogram_peak_normalize_test.sv]
`timescale 1ns / 100ps

module byte_histogram_peak_normalize_test;
    import bhpn_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  bin_count;
        logic [COUNT_BITS-1:0]  peak_count;
        logic [HEIGHT_BITS-1:0] plot_height;
        logic                   empty_flag;
    } histogram_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // predictor state
    logic [COUNT_BITS-1:0] model_bins [NUM_BINS];
    logic [COUNT_BITS-1:0] model_peak;

    histogram_result_t pending_results [$];
    int  error_count;
    int  cycle_count;
    bit  idle_enable;
    int  ready_stall_left;

    byte_histogram_peak_normalize dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [HEIGHT_BITS-1:0] plot_height_of(
        logic [COUNT_BITS-1:0] count, logic [COUNT_BITS-1:0] pk);
        logic [63:0] scaled;
        if (pk == '0) begin
            return FULL_SCALE;
        end
        scaled = (64'(count) * 64'd256) / 64'(pk);
        if (scaled >= 64'd256) begin
            return '0;
        end
        return FULL_SCALE - HEIGHT_BITS'(scaled);
    endfunction

    function automatic histogram_result_t apply_command(
        logic [1:0] cmd, logic [7:0] pix, logic [7:0] idx);
        histogram_result_t res;
        logic [COUNT_BITS-1:0] c;
        res = '0;
        if (cmd == CMD_ACCUMULATE) begin
            c = model_bins[pix];
            if (c != COUNT_MAX) begin
                c = c + 1'b1;
            end
            model_bins[pix] = c;
            if (c > model_peak) begin
                model_peak = c;
            end
        end else if (cmd == CMD_QUERY) begin
            res.bin_count   = model_bins[idx];
            res.plot_height = plot_height_of(model_bins[idx], model_peak);
            res.empty_flag  = (model_peak == '0);
        end else if (cmd == CMD_CLEAR) begin
            foreach (model_bins[i]) begin
                model_bins[i] = '0;
            end
            model_peak = '0;
        end
        res.peak_count = model_peak;
        return res;
    endfunction

    // sender: holds the command until accepted, then maybe idles a burst
    task automatic send_command(logic [1:0] cmd, logic [7:0] pix, logic [7:0] idx);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, idx, pix, cmd};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results.push_back(apply_command(cmd, pix, idx));
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // receiver backpressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn || !idle_enable) begin
            ready_stall_left = 0;
            m_tready <= 1'b1;
        end else if (ready_stall_left > 0) begin
            ready_stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            ready_stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        histogram_result_t want;
        histogram_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.bin_count   = m_tdata[21:0];
            got.peak_count  = m_tdata[43:22];
            got.plot_height = m_tdata[52:44];
            got.empty_flag  = m_tdata[53];
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.bin_count !== want.bin_count) begin
                    $error("bin_count expected %0d actual %0d",
                           want.bin_count, got.bin_count);
                    error_count++;
                end
                if (got.peak_count !== want.peak_count) begin
                    $error("peak_count expected %0d actual %0d",
                           want.peak_count, got.peak_count);
                    error_count++;
                end
                if (got.plot_height !== want.plot_height) begin
                    $error("plot_height expected %0d actual %0d",
                           want.plot_height, got.plot_height);
                    error_count++;
                end
                if (got.empty_flag !== want.empty_flag) begin
                    $error("empty_flag expected %0d actual %0d",
                           want.empty_flag, got.empty_flag);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_histogram();
        send_command(CMD_QUERY, 8'hFF, 8'h00);
        send_command(CMD_QUERY, 8'h00, 8'hFF);
        send_command(CMD_UNUSED, 8'hFF, 8'hFF);
        send_command(CMD_CLEAR, 8'hFF, 8'hFF);
        send_command(CMD_QUERY, 8'h5A, 8'hA5);
    endtask

    task automatic test_directed_extremes();
        send_command(CMD_ACCUMULATE, 8'h00, 8'hFF);
        send_command(CMD_ACCUMULATE, 8'hFF, 8'h00);
        send_command(CMD_QUERY, 8'h00, 8'hFF);
        // untouched bin with a nonzero peak gives full height, no empty flag
        send_command(CMD_QUERY, 8'hFF, 8'h80);
        send_command(CMD_ACCUMULATE, 8'h00, 8'h55);
        send_command(CMD_ACCUMULATE, 8'h55, 8'h00);
        send_command(CMD_ACCUMULATE, 8'hAA, 8'hFF);
        send_command(CMD_ACCUMULATE, 8'h00, 8'hAA);
        // bin at the peak reads as height zero
        send_command(CMD_QUERY, 8'hAA, 8'h00);
        send_command(CMD_QUERY, 8'h55, 8'hFF);
        send_command(CMD_QUERY, 8'h00, 8'h55);
        send_command(CMD_UNUSED, 8'h00, 8'h00);
        send_command(CMD_UNUSED, 8'hFF, 8'hFF);
        send_command(CMD_QUERY, 8'h00, 8'hFF);
        send_command(CMD_CLEAR, 8'h00, 8'h00);
        send_command(CMD_QUERY, 8'hFF, 8'h00);
        send_command(CMD_ACCUMULATE, 8'h80, 8'h00);
        send_command(CMD_QUERY, 8'h00, 8'h80);
    endtask

    task automatic random_command(output logic [1:0] cmd, output logic [7:0] pix,
                                  output logic [7:0] idx);
        int pick;
        pick = $urandom_range(0, 99);
        pix  = 8'($urandom_range(0, 255));
        idx  = 8'($urandom_range(0, 255));
        if (pick < 70) begin
            cmd = CMD_ACCUMULATE;
            // concentrate on a few bins so peaks and ratios grow varied
            if ($urandom_range(0, 4) < 3) begin
                pix = 8'($urandom_range(0, 7));
            end
        end else if (pick < 95) begin
            cmd = CMD_QUERY;
            if ($urandom_range(0, 2) < 2) begin
                idx = 8'($urandom_range(0, 7));
            end
        end else if (pick < 97) begin
            cmd = CMD_CLEAR;
        end else begin
            cmd = CMD_UNUSED;
        end
    endtask

    task automatic test_random_with_idling(int count);
        logic [1:0] cmd;
        logic [7:0] pix;
        logic [7:0] idx;
        idle_enable = 1'b1;
        repeat (count) begin
            random_command(cmd, pix, idx);
            send_command(cmd, pix, idx);
        end
    endtask

    task automatic test_random_streaming(int count);
        logic [1:0] cmd;
        logic [7:0] pix;
        logic [7:0] idx;
        idle_enable = 1'b0;
        repeat (count) begin
            random_command(cmd, pix, idx);
            send_command(cmd, pix, idx);
        end
    endtask

    initial begin
        idle_enable = 1'b1;
        foreach (model_bins[i]) begin
            model_bins[i] = '0;
        end
        model_peak = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_histogram();
        test_directed_extremes();
        test_random_with_idling(400);
        test_random_streaming(100);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
